>>> hdl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the selection sort engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int VALUE_W = 16;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

>>> hdl/sse_in_if.sv
// ----------------------------------------------------------------------------
// sse_in_if
// Input channel: one element per transfer, is_last closes the set.
// ----------------------------------------------------------------------------
interface sse_in_if
  import sse_pkg::*;
();
  logic   valid;
  logic   ready;
  value_t value;
  logic   is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

>>> hdl/sse_out_if.sv
// ----------------------------------------------------------------------------
// sse_out_if
// Result channel: one sorted element per transfer, final_res on the last.
// ----------------------------------------------------------------------------
interface sse_out_if
  import sse_pkg::*;
();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

>>> hdl/sse_store.sv
// ----------------------------------------------------------------------------
// sse_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sse_store
  import sse_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  value_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output value_t        rd_data
);

  value_t mem [DEPTH];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/selection_sort_engine_core.sv
// ----------------------------------------------------------------------------
// selection_sort_engine_core
// Collects a set of signed 16-bit elements, one per input transfer, until a
// transfer marked is_last arrives, then emits the set in ascending order, one
// element per result transfer, with final_res on the last one. Up to DEPTH
// elements are kept; further elements of a set are dropped silently (an
// is_last on a dropped element still closes the set). Input is accepted one
// element per cycle while loading. Once the set is closed the input is held
// off until the last result is taken. For each output position one compare
// unit scans the remaining elements through the single read port of the
// store, one element per cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module selection_sort_engine_core
  import sse_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  sse_in_if.sink   in_chan,
  sse_out_if.source out_chan
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // LOAD: taking elements. FETCH/FIRST: read the element at the current
  // position. SCAN: one compare per cycle against the running minimum.
  // SWAP: move the displaced element and present the minimum. EMIT: wait for
  // the result transfer.
  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_FIRST,
    S_SCAN,
    S_SWAP,
    S_EMIT
  } state_t;

  state_t        state_r,    state_nxt;
  logic [CW-1:0] cnt_r,      cnt_nxt;      // elements loaded so far
  logic [CW-1:0] count_r,    count_nxt;    // size of the closed set
  logic [AW-1:0] pos_r,      pos_nxt;      // output position being filled
  logic [AW-1:0] scan_r,     scan_nxt;     // index of the element in rd_data
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  value_t        best_val_r, best_val_nxt;
  value_t        pos_val_r,  pos_val_nxt;  // element displaced from pos_r
  logic          out_valid_r, out_valid_nxt;
  value_t        out_value_r, out_value_nxt;
  logic          out_final_r, out_final_nxt;

  // Last emitted value, kept for the ordering check below.
  value_t        prev_val_r;
  logic          have_prev_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;
  logic [AW-1:0] rd_addr;
  value_t        rd_data;

  logic          in_xfer;
  logic          out_xfer;

  sse_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_chan.ready         = (state_r == S_LOAD);
  assign in_xfer               = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sorted_value = out_value_r;
  assign out_chan.final_res    = out_final_r;
  assign out_xfer              = out_valid_r && out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    scan_nxt      = scan_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    pos_val_nxt   = pos_val_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;

    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = in_chan.value;
    rd_addr = pos_r;

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          // Full store: element dropped, is_last still honoured.
          if (cnt_r < CW'(DEPTH)) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_chan.is_last) begin
            count_nxt = (cnt_r < CW'(DEPTH)) ? cnt_r + CW'(1) : cnt_r;
            pos_nxt   = '0;
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        rd_addr   = pos_r;
        state_nxt = S_FIRST;
      end

      S_FIRST: begin
        pos_val_nxt  = rd_data;
        best_val_nxt = rd_data;
        best_idx_nxt = pos_r;
        rd_addr      = pos_r + AW'(1);
        scan_nxt     = pos_r + AW'(1);
        if (CW'(pos_r) + CW'(1) < count_r) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_SWAP;
        end
      end

      S_SCAN: begin
        // strict less-than: earliest index wins a tie
        if (rd_data < best_val_r) begin
          best_val_nxt = rd_data;
          best_idx_nxt = scan_r;
        end
        rd_addr  = scan_r + AW'(1);
        scan_nxt = scan_r + AW'(1);
        if (CW'(scan_r) + CW'(1) >= count_r) begin
          state_nxt = S_SWAP;
        end
      end

      S_SWAP: begin
        // The minimum leaves straight for the output; only the displaced
        // element needs writing back.
        wr_en         = 1'b1;
        wr_addr       = best_idx_r;
        wr_data       = pos_val_r;
        out_valid_nxt = 1'b1;
        out_value_nxt = best_val_r;
        out_final_nxt = (CW'(pos_r) + CW'(1) == count_r);
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            pos_nxt   = pos_r + AW'(1);
            state_nxt = S_FETCH;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_xfer) begin
        have_prev_r <= !out_final_r;
      end
    end
    count_r     <= count_nxt;
    pos_r       <= pos_nxt;
    scan_r      <= scan_nxt;
    best_idx_r  <= best_idx_nxt;
    best_val_r  <= best_val_nxt;
    pos_val_r   <= pos_val_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    if (out_xfer) begin
      prev_val_r <= out_value_r;
    end
  end

  // Results of one set leave in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && have_prev_r) |-> (out_value_r >= prev_val_r))
    else $error("result out of order");

  // The fill count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // In SCAN the running minimum is at or past pos_r, and scan_r < count_r.
  a_best_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (best_idx_r >= pos_r && CW'(scan_r) < count_r))
    else $error("scan outside the unsorted range");

  // After the final result the store is empty again.
  a_empty_after_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_final_r) |=> (cnt_r == '0 && state_r == S_LOAD))
    else $error("store not emptied after final result");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks selection_sort_engine_core. Sets of signed elements go in through the
// input channel, while a predictor keeps its own copy of the store. On every
// is_last transfer it sorts that copy and queues the ascending values it
// expects. Each result transfer is checked against the oldest queued value
// and its final flag. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
  import sse_pkg::*;
();

  localparam int     DEPTH   = 64;
  localparam value_t VAL_MIN = 16'sh8000;
  localparam value_t VAL_MAX = 16'sh7FFF;

  // data shapes for random sets
  typedef enum int {
    SHAPE_WIDE,
    SHAPE_NARROW,
    SHAPE_EDGES
  } data_shape_t;

  typedef struct {
    value_t val;
    logic   fin;
  } sorted_elem_t;

  logic clk;
  logic rst_n;

  sse_in_if  in_chan ();
  sse_out_if out_chan ();

  selection_sort_engine_core #(
    .DEPTH (DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state: its own copy of the element store
  value_t       held_vals [DEPTH];
  int           held_count;
  sorted_elem_t sorted_due [$];
  sorted_elem_t head_due;
  int           mismatch_cnt;
  bit           in_gaps_on;
  bit           out_stall_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stores the element unless the store is full; on is_last, sorts the held
  // set (strict less-than, earliest index wins) and queues it for checking.
  function automatic void predict_transfer(value_t val, logic last);
    value_t       hold;
    int           best;
    sorted_elem_t ent;
    if (held_count < DEPTH) begin
      held_vals[held_count] = val;
      held_count++;
    end
    if (last) begin
      for (int pos = 0; pos + 1 < held_count; pos++) begin
        best = pos;
        for (int scan = pos + 1; scan < held_count; scan++) begin
          if (held_vals[scan] < held_vals[best]) best = scan;
        end
        hold            = held_vals[pos];
        held_vals[pos]  = held_vals[best];
        held_vals[best] = hold;
      end
      for (int k = 0; k < held_count; k++) begin
        ent.val = held_vals[k];
        ent.fin = (k == held_count - 1);
        sorted_due.push_back(ent);
      end
      held_count = 0;
    end
  endfunction

  // One input transfer. Valid is left high on return so the next call can
  // follow back to back; anything that lets time pass must lower it first.
  task automatic send_elem(input value_t val, input logic last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.value   <= val;
    in_chan.is_last <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_transfer(val, last);
  endtask

  // Holds the input off until every queued result has been taken.
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic value_t rand_value(data_shape_t shape);
    value_t v;
    case (shape)
      SHAPE_NARROW: begin
        v = value_t'($urandom_range(0, 7)) - 16'sd4;  // plenty of ties
      end
      SHAPE_EDGES: begin
        case ($urandom_range(0, 4))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          3:       v = -16'sd1;
          default: v = value_t'($urandom());
        endcase
      end
      default: begin
        v = value_t'($urandom());
      end
    endcase
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_extremes();
    send_elem(VAL_MAX, 1'b0);
    send_elem(VAL_MIN, 1'b0);
    send_elem(16'sd0, 1'b0);
    send_elem(-16'sd1, 1'b0);
    send_elem(16'sd1, 1'b1);
    // single element sets go out unchanged
    send_elem(VAL_MIN, 1'b1);
    send_elem(VAL_MAX, 1'b1);
    // duplicates
    send_elem(16'sd5, 1'b0);
    send_elem(-16'sd5, 1'b0);
    send_elem(16'sd5, 1'b0);
    send_elem(16'sd5, 1'b1);
  endtask

  task automatic test_ordering();
    for (int i = 0; i < 4; i++) send_elem(value_t'(-900 + 600 * i), i == 3);
    for (int i = 0; i < 5; i++) send_elem(value_t'(1000 - 450 * i), i == 4);
    send_elem(-16'sd7, 1'b0);
    send_elem(-16'sd7, 1'b1);
  endtask

  // A set running past a full store: extra elements are dropped, and an
  // is_last on a dropped element still closes the set.
  task automatic test_capacity();
    for (int i = 0; i <= DEPTH + 1; i++) send_elem(rand_value(SHAPE_EDGES), i == DEPTH + 1);
  endtask

  task automatic test_random_sets();
    int          sent;
    int          sets;
    int          size;
    int          pick;
    data_shape_t shape;
    sent = 0;
    sets = 0;
    while (sent < 120) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)     size = $urandom_range(DEPTH - 4, DEPTH + 4);
      else if (pick < 4) size = $urandom_range(11, 24);
      else               size = $urandom_range(1, 10);
      shape        = data_shape_t'($urandom_range(0, 2));
      in_gaps_on   = ($urandom_range(0, 3) != 0);
      out_stall_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < size; i++) send_elem(rand_value(shape), i == size - 1);
      sent += size;
      sets++;
      // sender backs off until the engine has emptied once
      if (sets == 2) wait_drain();
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls on ready, plus the checker
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_stall_on ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!(out_chan.valid && out_chan.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d final %0b",
                 $time, out_chan.sorted_value, out_chan.final_res);
        mismatch_cnt++;
      end else begin
        head_due = sorted_due.pop_front();
        if (out_chan.sorted_value !== head_due.val) begin
          $display("%0t: sorted_value expected %0d, got %0d",
                   $time, head_due.val, out_chan.sorted_value);
          mismatch_cnt++;
        end
        if (out_chan.final_res !== head_due.fin) begin
          $display("%0t: final_res expected %0b, got %0b",
                   $time, head_due.fin, out_chan.final_res);
          mismatch_cnt++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.value   <= '0;
    in_chan.is_last <= 1'b0;
    held_count   = 0;
    mismatch_cnt = 0;
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    test_ordering();
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    test_capacity();
    test_random_sets();

    wait_drain();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> selection_sort_engine_core.f
hdl/sse_pkg.sv
hdl/sse_in_if.sv
hdl/sse_out_if.sv
hdl/sse_store.sv
hdl/selection_sort_engine_core.sv
dv/testbench.sv
